FILE: src/sample_period_statistics_defines.svh
// ----------------------------------------------------------------------------
// sample_period_statistics_defines
// assertion macros shared by the verification side of the block
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PERIOD_STATISTICS_DEFINES_SVH
`define SAMPLE_PERIOD_STATISTICS_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/spst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spst_pkg
// shared widths, defaults and types of the sample period statistics block
// ----------------------------------------------------------------------------
package spst_pkg;

    localparam int READING_W      = 16;
    localparam int PERIOD_NUM_W   = 4;
    localparam int SWING_W        = 5;
    localparam int POSITION_W     = 9;
    localparam int THRESHOLD_W    = 16;

    localparam int SPP_DEFAULT    = 30;
    localparam int PPR_DEFAULT    = 12;

    localparam logic [THRESHOLD_W-1:0] SWING_THRESHOLD_RST = 16'd500;
    localparam logic [SWING_W-1:0]     SWING_MAX           = 5'd31;

    // load strobes of the three mean divider stages
    typedef struct packed {
        logic mag;
        logic prod;
        logic quot;
    } spst_div_ld_t;

    // everything a finished period carries besides the two sums
    typedef struct packed {
        logic                         run_end;
        logic [PERIOD_NUM_W-1:0]      period_number;
        logic [SWING_W-1:0]           swing;
        logic [POSITION_W-1:0]        max_pos;
        logic signed [READING_W-1:0]  max_rd;
        logic [POSITION_W-1:0]        min_pos;
        logic signed [READING_W-1:0]  min_rd;
    } spst_event_t;

endpackage

FILE: src/spst_mean_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spst_mean_div
// three-stage signed division by a constant, truncated toward zero
// ----------------------------------------------------------------------------
module spst_mean_div
    import spst_pkg::*;
#(
    parameter int SUM_W   = 21,
    parameter int DIVISOR = SPP_DEFAULT
)(
    input  logic                        clk,
    input  spst_div_ld_t                ld,
    input  logic signed [SUM_W-1:0]     sum,
    output logic signed [READING_W-1:0] mean
);

    // magnitude times ceil(2^SHIFT / DIVISOR), shifted down, is exact for
    // every magnitude below 2^MAG_W
    localparam int MAG_W  = SUM_W;
    localparam int LOG_D  = $clog2(DIVISOR);
    localparam int SHIFT  = MAG_W + LOG_D;
    localparam int MULT_W = MAG_W + 1;
    localparam int PROD_W = MAG_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT =
        MULT_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [MAG_W-1:0]     mag_next;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_a_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_b_reg;
    logic [READING_W-1:0] quot;
    logic signed [READING_W-1:0] mean_next;
    logic signed [READING_W-1:0] mean_reg;

    always_comb
    begin
        mag_next = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end

    always_comb
    begin
        quot      = prod_reg[SHIFT +: READING_W];
        mean_next = neg_b_reg ? signed'(-quot) : signed'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (ld.mag)
        begin
            mag_reg   <= mag_next;
            neg_a_reg <= sum[SUM_W-1];
        end
        if (ld.prod)
        begin
            prod_reg  <= PROD_W'(mag_reg) * PROD_W'(MULT);
            neg_b_reg <= neg_a_reg;
        end
        if (ld.quot)
        begin
            mean_reg  <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

FILE: src/sample_period_statistics.sv
// ----------------------------------------------------------------------------
// sample_period_statistics: period and run statistics over a sample stream
// path: input and sum registers, divider mag, prod and quot stages; run summary follows
// rate: one sample per cycle unless stalled; a run end holds the output for both summaries
// reset: asynchronous active low, clears counters, sums, extremes and valids, threshold 500
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sample_period_statistics
    import spst_pkg::*;
#(
    parameter int SAMPLES_PER_PERIOD = SPP_DEFAULT,
    parameter int PERIODS_PER_RUN    = PPR_DEFAULT
)(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_wr_en,
    input  logic [THRESHOLD_W-1:0]       cfg_wr_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [READING_W-1:0]  sample,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         summary_kind,
    output logic [PERIOD_NUM_W-1:0]      period_number,
    output logic signed [READING_W-1:0]  period_mean,
    output logic [SWING_W-1:0]           swing_total,
    output logic signed [READING_W-1:0]  run_mean,
    output logic [POSITION_W-1:0]        hottest_position,
    output logic signed [READING_W-1:0]  hottest_reading,
    output logic [POSITION_W-1:0]        coldest_position,
    output logic signed [READING_W-1:0]  coldest_reading,
    output logic                         final_flag
);

    localparam int RUN_LEN = SAMPLES_PER_PERIOD * PERIODS_PER_RUN;
    localparam int SLOT_W  = $clog2(SAMPLES_PER_PERIOD);
    localparam int PSUM_W  = READING_W + $clog2(SAMPLES_PER_PERIOD);
    localparam int RSUM_W  = READING_W + $clog2(RUN_LEN);

    localparam logic [SLOT_W-1:0]       LAST_SLOT   = SLOT_W'(SAMPLES_PER_PERIOD - 1);
    localparam logic [PERIOD_NUM_W-1:0] LAST_PERIOD = PERIOD_NUM_W'(PERIODS_PER_RUN - 1);

    // configuration
    logic [THRESHOLD_W-1:0] thr_reg;

    // pipeline valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic phase_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic adv1, ld2;
    spst_div_ld_t div_ld;

    // input stage
    logic signed [READING_W-1:0] smp_reg;

    // running state
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [PERIOD_NUM_W-1:0]      pcount_reg, pcount_next;
    logic [POSITION_W-1:0]        runpos_reg, runpos_next, runpos_inc;
    logic signed [PSUM_W-1:0]     psum_reg, psum_next, psum_add;
    logic signed [RSUM_W-1:0]     rsum_reg, rsum_next, rsum_add;
    logic signed [READING_W-1:0]  prev_reg;
    logic [SWING_W-1:0]           swing_reg, swing_next, swing_add;
    logic signed [READING_W-1:0]  max_reg, max_next;
    logic [POSITION_W-1:0]        maxpos_reg, maxpos_next;
    logic signed [READING_W-1:0]  min_reg, min_next;
    logic [POSITION_W-1:0]        minpos_reg, minpos_next;

    logic first_of_period, first_of_run, period_end, run_end;
    logic signed [READING_W:0] diff;
    logic [READING_W:0]        diff_mag;
    logic                      is_swing;

    // result pipeline payload
    spst_event_t              ev_next, ev2_reg, ev3_reg, ev4_reg, ev5_reg;
    logic signed [PSUM_W-1:0] psum2_reg;
    logic signed [RSUM_W-1:0] rsum2_reg;
    logic signed [READING_W-1:0] pmean, rmean;
    logic show_run;

    // ---------------------------------------------------------------- control
    always_comb
    begin
        rdy5     = !v5_reg || (!out_stall && (!ev5_reg.run_end || phase_reg));
        rdy4     = !v4_reg || rdy5;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        // a sample that closes no period retires without waiting on the results
        adv1     = v1_reg && (rdy2 || !period_end);
        rdy1     = !v1_reg || adv1;
        in_stall = !rdy1;
        ld2      = adv1 && period_end;
        div_ld.mag  = rdy3 && v2_reg;
        div_ld.prod = rdy4 && v3_reg;
        div_ld.quot = rdy5 && v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= ld2;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg    <= v4_reg;
                phase_reg <= 1'b0;
            end
            else if (v5_reg && !out_stall)
            begin
                // period summary of a run end went out, run summary is next
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= SWING_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            smp_reg <= sample;
        end
    end

    // ---------------------------------------------------------- state update
    always_comb
    begin
        first_of_period = (slot_reg == '0);
        first_of_run    = (runpos_reg == '0);
        period_end      = (slot_reg == LAST_SLOT);
        run_end         = period_end && (pcount_reg == LAST_PERIOD);

        runpos_inc = runpos_reg + POSITION_W'(1);
        psum_add   = psum_reg + PSUM_W'(smp_reg);
        rsum_add   = rsum_reg + RSUM_W'(smp_reg);

        diff     = (READING_W+1)'(smp_reg) - (READING_W+1)'(prev_reg);
        diff_mag = diff[READING_W] ? unsigned'(-diff) : unsigned'(diff);
        is_swing = !first_of_period && (diff_mag > {1'b0, thr_reg});
        swing_add = (is_swing && swing_reg != SWING_MAX) ? swing_reg + SWING_W'(1)
                                                          : swing_reg;

        if (first_of_run || smp_reg > max_reg)
        begin
            max_next    = smp_reg;
            maxpos_next = runpos_inc;
        end
        else
        begin
            max_next    = max_reg;
            maxpos_next = maxpos_reg;
        end
        if (first_of_run || smp_reg < min_reg)
        begin
            min_next    = smp_reg;
            minpos_next = runpos_inc;
        end
        else
        begin
            min_next    = min_reg;
            minpos_next = minpos_reg;
        end

        ev_next.run_end       = run_end;
        ev_next.period_number = pcount_reg;
        ev_next.swing         = swing_add;
        ev_next.max_pos       = maxpos_next;
        ev_next.max_rd        = max_next;
        ev_next.min_pos       = minpos_next;
        ev_next.min_rd        = min_next;

        slot_next   = period_end ? '0 : slot_reg + SLOT_W'(1);
        psum_next   = period_end ? '0 : psum_add;
        swing_next  = period_end ? '0 : swing_add;
        pcount_next = run_end ? '0 : (period_end ? pcount_reg + PERIOD_NUM_W'(1)
                                                 : pcount_reg);
        runpos_next = run_end ? '0 : runpos_inc;
        rsum_next   = run_end ? '0 : rsum_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            pcount_reg <= '0;
            runpos_reg <= '0;
            psum_reg   <= '0;
            rsum_reg   <= '0;
            prev_reg   <= '0;
            swing_reg  <= '0;
            max_reg    <= '0;
            maxpos_reg <= '0;
            min_reg    <= '0;
            minpos_reg <= '0;
        end
        else if (adv1)
        begin
            slot_reg   <= slot_next;
            pcount_reg <= pcount_next;
            runpos_reg <= runpos_next;
            psum_reg   <= psum_next;
            rsum_reg   <= rsum_next;
            prev_reg   <= smp_reg;
            swing_reg  <= swing_next;
            max_reg    <= max_next;
            maxpos_reg <= maxpos_next;
            min_reg    <= min_next;
            minpos_reg <= minpos_next;
        end
    end

    // -------------------------------------------------------- result pipeline
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            ev2_reg   <= ev_next;
            psum2_reg <= psum_add;
            rsum2_reg <= rsum_add;
        end
        if (div_ld.mag)
        begin
            ev3_reg <= ev2_reg;
        end
        if (div_ld.prod)
        begin
            ev4_reg <= ev3_reg;
        end
        if (div_ld.quot)
        begin
            ev5_reg <= ev4_reg;
        end
    end

    spst_mean_div #(
        .SUM_W   (PSUM_W),
        .DIVISOR (SAMPLES_PER_PERIOD)
    ) u_period_div (
        .clk  (clk),
        .ld   (div_ld),
        .sum  (psum2_reg),
        .mean (pmean)
    );

    spst_mean_div #(
        .SUM_W   (RSUM_W),
        .DIVISOR (RUN_LEN)
    ) u_run_div (
        .clk  (clk),
        .ld   (div_ld),
        .sum  (rsum2_reg),
        .mean (rmean)
    );

    // ----------------------------------------------------------------- output
    always_comb
    begin
        show_run         = ev5_reg.run_end && phase_reg;
        out_valid        = v5_reg;
        summary_kind     = show_run;
        final_flag       = !ev5_reg.run_end || phase_reg;
        period_number    = show_run ? '0 : ev5_reg.period_number;
        period_mean      = show_run ? '0 : pmean;
        swing_total      = show_run ? '0 : ev5_reg.swing;
        run_mean         = show_run ? rmean : '0;
        hottest_position = show_run ? ev5_reg.max_pos : '0;
        hottest_reading  = show_run ? ev5_reg.max_rd : '0;
        coldest_position = show_run ? ev5_reg.min_pos : '0;
        coldest_reading  = show_run ? ev5_reg.min_rd : '0;
    end

endmodule

FILE: src/spst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spst_checker
// port-level checks of the sample period statistics block
// ----------------------------------------------------------------------------
`include "sample_period_statistics_defines.svh"

module spst_checker
    import spst_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         summary_kind,
    input  logic [PERIOD_NUM_W-1:0]      period_number,
    input  logic signed [READING_W-1:0]  period_mean,
    input  logic [SWING_W-1:0]           swing_total,
    input  logic signed [READING_W-1:0]  run_mean,
    input  logic [POSITION_W-1:0]        hottest_position,
    input  logic signed [READING_W-1:0]  hottest_reading,
    input  logic [POSITION_W-1:0]        coldest_position,
    input  logic signed [READING_W-1:0]  coldest_reading,
    input  logic                         final_flag
);

    logic [92:0] out_word;

    assign out_word = {summary_kind, period_number, period_mean, swing_total, run_mean,
                       hottest_position, hottest_reading, coldest_position,
                       coldest_reading, final_flag};

    // stalled result holds
    `SPST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

    // a run summary is always the last result of its sample
    `SPST_ASSERT_NOW(a_run_final, out_valid && summary_kind, final_flag, "run summary not final")

    // a non-final period summary is followed right away by the run summary
    `SPST_ASSERT_NEXT(a_run_follows, out_valid && !summary_kind && !final_flag && !out_stall, out_valid && summary_kind, "run summary missing after period summary")

    // unused period fields of a run summary read as zero
    `SPST_ASSERT_NOW(a_run_zero, out_valid && summary_kind, period_number == '0 && period_mean == '0 && swing_total == '0, "run summary period fields not zero")

endmodule

bind sample_period_statistics spst_checker u_spst_checker (.*);

FILE: sim/tb_sample_period_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_period_statistics
// self-checking bench: a table of constant and alternating periods with known
// means and swing counts, then random readings under several idle and stall
// mixes, every summary compared field by field with an in-bench predictor
// ----------------------------------------------------------------------------
module tb_sample_period_statistics;
    import spst_pkg::*;

    localparam int SAMPLES_PER_PERIOD = SPP_DEFAULT;
    localparam int PERIODS_PER_RUN    = PPR_DEFAULT;
    localparam int SAMPLES_PER_RUN    = SAMPLES_PER_PERIOD * PERIODS_PER_RUN;
    localparam int SETTLE_CYCLES      = 12;
    localparam int DRAIN_LIMIT        = 20000;
    localparam int HOLD_CYCLES        = 240;
    localparam int PHASE_ITEMS        = 300;
    localparam int PHASE_COUNT        = 5;
    localparam int PRINT_LIMIT        = 40;
    localparam int ROW_COUNT          = 14;

    localparam logic KIND_PERIOD = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                         kind;
        logic [PERIOD_NUM_W-1:0]      period_number;
        logic signed [READING_W-1:0]  period_mean;
        logic [SWING_W-1:0]           swing_total;
        logic signed [READING_W-1:0]  run_mean;
        logic [POSITION_W-1:0]        hottest_position;
        logic signed [READING_W-1:0]  hottest_reading;
        logic [POSITION_W-1:0]        coldest_position;
        logic signed [READING_W-1:0]  coldest_reading;
        logic                         last;
    } summary_t;

    // one period of readings alternating between two values
    typedef struct packed {
        logic signed [READING_W-1:0]  even_reading;
        logic signed [READING_W-1:0]  odd_reading;
        logic                         write_threshold;
        logic [THRESHOLD_W-1:0]       threshold;
        logic                         fixed_result;
        logic signed [READING_W-1:0]  mean;
        logic [SWING_W-1:0]           swings;
    } period_row_t;

    localparam period_row_t PERIOD_ROWS [ROW_COUNT] = '{
        '{16'sd0,      16'sd0,      1'b0, 16'd0,     1'b1, 16'sd0,     5'd0},
        '{16'sd32767,  16'sd32767,  1'b0, 16'd0,     1'b1, 16'sd32767, 5'd0},
        '{16'sh8000,   16'sh8000,   1'b0, 16'd0,     1'b1, 16'sh8000,  5'd0},
        '{16'sd250,    -16'sd251,   1'b0, 16'd0,     1'b1, 16'sd0,     5'd29},
        '{16'sd250,    -16'sd250,   1'b0, 16'd0,     1'b1, 16'sd0,     5'd0},
        '{16'sd32767,  16'sh8000,   1'b1, 16'hFFFF,  1'b1, 16'sd0,     5'd0},
        '{16'sd0,      16'sd1,      1'b1, 16'd0,     1'b1, 16'sd0,     5'd29},
        '{16'sd100,    16'sd600,    1'b1, 16'd500,   1'b1, 16'sd350,   5'd0},
        '{16'sd100,    16'sd601,    1'b0, 16'd0,     1'b1, 16'sd350,   5'd29},
        '{-16'sd7,     -16'sd8,     1'b1, 16'd0,     1'b1, -16'sd7,    5'd29},
        '{16'sd5,      16'sd5,      1'b1, 16'hFFFF,  1'b1, 16'sd5,     5'd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'd0,     1'b1, -16'sd1,    5'd0},
        '{16'sd12345,  -16'sd12345, 1'b1, 16'd20000, 1'b0, 16'sd0,     5'd0},
        '{-16'sd30000, 16'sd29999,  1'b0, 16'd0,     1'b0, 16'sd0,     5'd0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [THRESHOLD_W-1:0]       cfg_wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [READING_W-1:0]  sample = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         summary_kind;
    logic [PERIOD_NUM_W-1:0]      period_number;
    logic signed [READING_W-1:0]  period_mean;
    logic [SWING_W-1:0]           swing_total;
    logic signed [READING_W-1:0]  run_mean;
    logic [POSITION_W-1:0]        hottest_position;
    logic signed [READING_W-1:0]  hottest_reading;
    logic [POSITION_W-1:0]        coldest_position;
    logic signed [READING_W-1:0]  coldest_reading;
    logic                         final_flag;

    summary_t pending_summaries [$];
    int       mismatches = 0;

    // handshake mix, set per phase by the stimulus
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_ticket = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // predictor state
    logic [THRESHOLD_W-1:0] model_threshold = SWING_THRESHOLD_RST;
    int slot = 0;
    int period_idx = 0;
    int run_pos = 0;
    int period_total = 0;
    int run_total = 0;
    int prev_reading = 0;
    int swings = 0;
    int max_rd = 0;
    int max_pos = 0;
    int min_rd = 0;
    int min_pos = 0;

    // table rows with a known period summary replace the computed one
    logic                         fixed_valid = 1'b0;
    logic signed [READING_W-1:0]  fixed_mean = '0;
    logic [SWING_W-1:0]           fixed_swings = '0;

    sample_period_statistics u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .summary_kind     (summary_kind),
        .period_number    (period_number),
        .period_mean      (period_mean),
        .swing_total      (swing_total),
        .run_mean         (run_mean),
        .hottest_position (hottest_position),
        .hottest_reading  (hottest_reading),
        .coldest_position (coldest_position),
        .coldest_reading  (coldest_reading),
        .final_flag       (final_flag)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    function automatic void accumulate_reading(input logic signed [READING_W-1:0] reading);
        int       x;
        int       diff;
        bit       first_of_run;
        summary_t s;
        x = reading;
        first_of_run = (run_pos == 0);
        run_pos++;
        period_total += x;
        run_total += x;
        // first reading of a period has nothing to swing from
        if (slot != 0)
        begin
            diff = x - prev_reading;
            if (diff < 0)
            begin
                diff = -diff;
            end
            if (diff > int'(model_threshold) && swings < int'(SWING_MAX))
            begin
                swings++;
            end
        end
        prev_reading = x;
        if (first_of_run || x > max_rd)
        begin
            max_rd = x;
            max_pos = run_pos;
        end
        if (first_of_run || x < min_rd)
        begin
            min_rd = x;
            min_pos = run_pos;
        end
        slot++;
        if (slot == SAMPLES_PER_PERIOD)
        begin
            s = '0;
            s.kind = KIND_PERIOD;
            s.period_number = PERIOD_NUM_W'(period_idx);
            s.period_mean = READING_W'(period_total / SAMPLES_PER_PERIOD);
            s.swing_total = SWING_W'(swings);
            s.last = 1'b1;
            if (fixed_valid)
            begin
                s.period_mean = fixed_mean;
                s.swing_total = fixed_swings;
            end
            slot = 0;
            period_total = 0;
            swings = 0;
            period_idx++;
            if (period_idx == PERIODS_PER_RUN)
            begin
                s.last = 1'b0;
                pending_summaries.push_back(s);
                s = '0;
                s.kind = KIND_RUN;
                s.run_mean = READING_W'(run_total / SAMPLES_PER_RUN);
                s.hottest_position = POSITION_W'(max_pos);
                s.hottest_reading = READING_W'(max_rd);
                s.coldest_position = POSITION_W'(min_pos);
                s.coldest_reading = READING_W'(min_rd);
                s.last = 1'b1;
                period_idx = 0;
                run_pos = 0;
                run_total = 0;
                max_rd = 0;
                max_pos = 0;
                min_rd = 0;
                min_pos = 0;
            end
            pending_summaries.push_back(s);
        end
    endfunction

    // called just after a falling edge, returns just after a falling edge once the reading was taken
    task automatic send_reading(input logic signed [READING_W-1:0] reading);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= reading;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        accumulate_reading(reading);
        @(negedge clk);
    endtask

    // mid-period readings give no result, so settle past the pipeline too
    task automatic wait_for_summaries();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_summaries.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THRESHOLD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        model_threshold = value;
    endtask

    // receiver: random stall, or a long hold-off when a ticket is raised
    always @(negedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        summary_t got;
        summary_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {summary_kind, period_number, period_mean, swing_total, run_mean,
                   hottest_position, hottest_reading, coldest_position,
                   coldest_reading, final_flag};
            if (pending_summaries.size() == 0)
            begin
                report_mismatch("summary with none pending", 32'(got.kind), 32'd0);
            end
            else
            begin
                want = pending_summaries.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("summary_kind", 32'(got.kind), 32'(want.kind));
                if (got.period_number !== want.period_number)
                    report_mismatch("period_number", 32'(got.period_number),
                                    32'(want.period_number));
                if (got.period_mean !== want.period_mean)
                    report_mismatch("period_mean", 32'(got.period_mean),
                                    32'(want.period_mean));
                if (got.swing_total !== want.swing_total)
                    report_mismatch("swing_total", 32'(got.swing_total),
                                    32'(want.swing_total));
                if (got.run_mean !== want.run_mean)
                    report_mismatch("run_mean", 32'(got.run_mean), 32'(want.run_mean));
                if (got.hottest_position !== want.hottest_position)
                    report_mismatch("hottest_position", 32'(got.hottest_position),
                                    32'(want.hottest_position));
                if (got.hottest_reading !== want.hottest_reading)
                    report_mismatch("hottest_reading", 32'(got.hottest_reading),
                                    32'(want.hottest_reading));
                if (got.coldest_position !== want.coldest_position)
                    report_mismatch("coldest_position", 32'(got.coldest_position),
                                    32'(want.coldest_position));
                if (got.coldest_reading !== want.coldest_reading)
                    report_mismatch("coldest_reading", 32'(got.coldest_reading),
                                    32'(want.coldest_reading));
                if (got.last !== want.last)
                    report_mismatch("final_flag", 32'(got.last), 32'(want.last));
            end
        end
    end

    initial
    begin
        idle_mode_t                   mode;
        int                           row;
        int                           phase;
        int                           item;
        int                           cand;
        int                           delta;
        int                           last_sent;
        logic signed [READING_W-1:0]  reading;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // table of whole periods, aligned with period boundaries from reset
        for (row = 0; row < ROW_COUNT; row++)
        begin
            if (PERIOD_ROWS[row].write_threshold)
            begin
                wait_for_summaries();
                write_threshold(PERIOD_ROWS[row].threshold);
            end
            fixed_valid = PERIOD_ROWS[row].fixed_result;
            fixed_mean = PERIOD_ROWS[row].mean;
            fixed_swings = PERIOD_ROWS[row].swings;
            for (item = 0; item < SAMPLES_PER_PERIOD; item++)
            begin
                send_reading((item % 2 == 0) ? PERIOD_ROWS[row].even_reading
                                             : PERIOD_ROWS[row].odd_reading);
            end
        end
        fixed_valid = 1'b0;
        last_sent = PERIOD_ROWS[ROW_COUNT-1].odd_reading;

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: mode = IDLE_NONE;
                1: mode = IDLE_SENDER;
                2: mode = IDLE_RECEIVER;
                3: mode = IDLE_BOTH;
                default: mode = IDLE_NONE;
            endcase
            wait_for_summaries();
            case (phase)
                0: write_threshold(THRESHOLD_W'($urandom_range(200, 1500)));
                1: write_threshold('0);
                2: write_threshold('1);
                3: write_threshold(THRESHOLD_W'($urandom_range(0, 65535)));
                default: write_threshold(THRESHOLD_W'($urandom_range(0, 3000)));
            endcase
            send_idle_pct = (mode == IDLE_SENDER) ? 88 : (mode == IDLE_BOTH) ? 22 : 0;
            stall_pct = (mode == IDLE_RECEIVER) ? 88 : (mode == IDLE_BOTH) ? 22 : 0;
            // back-pressure: output held while readings keep coming
            if (phase == 0)
            begin
                hold_ticket++;
            end
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: cand = int'($urandom_range(0, 65535)) - 32768;
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0: cand = 32767;
                            1: cand = -32768;
                            2: cand = 0;
                            default: cand = -1;
                        endcase
                    end
                    3, 4, 5, 6:
                    begin
                        // change right around the swing limit
                        delta = int'(model_threshold) + int'($urandom_range(0, 4)) - 2;
                        if ($urandom_range(0, 1) == 1)
                        begin
                            delta = -delta;
                        end
                        cand = last_sent + delta;
                    end
                    default: cand = last_sent + int'($urandom_range(0, 600)) - 300;
                endcase
                if (cand > 32767)
                begin
                    cand = 32767;
                end
                if (cand < -32768)
                begin
                    cand = -32768;
                end
                reading = READING_W'(cand);
                send_reading(reading);
                last_sent = cand;
            end
        end

        wait_for_summaries();
        if (pending_summaries.size() != 0)
        begin
            report_mismatch("summaries never arrived", 32'(pending_summaries.size()), 32'd0);
        end
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
